// ===== hw/rtl/bdsl_pkg.sv =====
// Shared types and constants for the push-button short/long press qualifier.
`timescale 1ns / 1ps
`default_nettype none

package bdsl_pkg;

  // Payload widths.
  localparam int unsigned SampleWidth = 10;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned EventWidth  = 2;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 10;

  // Request kinds.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // Press event codes.
  localparam logic [EventWidth-1:0] EVT_NONE  = 2'd0;
  localparam logic [EventWidth-1:0] EVT_SHORT = 2'd1;
  localparam logic [EventWidth-1:0] EVT_LONG  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CFG_PRESS_THRESHOLD  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE_TICKS   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_LONG_PRESS_TICKS = 2'd2;

  // Configuration reset values.
  localparam logic [SampleWidth-1:0] PRESS_THRESHOLD_RST  = 10'd255;
  localparam logic [CountWidth-1:0]  DEBOUNCE_TICKS_RST   = 8'd5;
  localparam logic [CountWidth-1:0]  LONG_PRESS_TICKS_RST = 8'd100;

  // Value loaded into the hold counter when a press is confirmed.
  localparam logic [CountWidth-1:0] HOLD_RELOAD = 8'hff;

  // One result item as it travels from the qualifier to the output buffer.
  typedef struct packed {
    logic [EventWidth-1:0] press_event;
  } evt_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bdsl_if.sv =====
// Valid/ready channel interfaces for button requests and press events.
`timescale 1ns / 1ps
`default_nettype none

interface bdsl_req_if;
  import bdsl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [SampleWidth-1:0] adc_sample;

  modport source (output valid, output req_type, output adc_sample, input ready);
  modport sink   (input valid, input req_type, input adc_sample, output ready);
endinterface

interface bdsl_evt_if;
  import bdsl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [EventWidth-1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink   (input valid, input press_event, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bdsl_qual.sv =====
// Press qualifier: configuration registers, counters and the six-stage machine.
`timescale 1ns / 1ps
`default_nettype none

module bdsl_qual (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bdsl_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [bdsl_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  input  wire logic                             push_i,
  input  wire logic                             req_type_i,
  input  wire logic [bdsl_pkg::SampleWidth-1:0] adc_sample_i,
  output bdsl_pkg::evt_t                        evt_o
);
  import bdsl_pkg::*;

  // Stage codes.
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CONFIRM = 3'd1;
  localparam logic [2:0] ST_HELD    = 3'd2;
  localparam logic [2:0] ST_RELEASE = 3'd3;
  localparam logic [2:0] ST_LONG    = 3'd4;
  localparam logic [2:0] ST_WAIT    = 3'd5;

  logic [SampleWidth-1:0] threshold_q;
  logic [CountWidth-1:0]  deb_ticks_q;
  logic [CountWidth-1:0]  long_ticks_q;

  logic [2:0]            stage_q, stage_d;
  logic [CountWidth-1:0] deb_cnt_q, deb_cnt_d;
  logic [CountWidth-1:0] hold_cnt_q, hold_cnt_d;

  logic                  pressed;
  logic                  due;
  logic [CountWidth-1:0] limit;

  // Configuration writes; the user must write only while the block is idle, the block itself does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= PRESS_THRESHOLD_RST;
      deb_ticks_q  <= DEBOUNCE_TICKS_RST;
      long_ticks_q <= LONG_PRESS_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESS_THRESHOLD:  threshold_q  <= cfg_wdata_i;
        CFG_DEBOUNCE_TICKS:   deb_ticks_q  <= cfg_wdata_i[CountWidth-1:0];
        CFG_LONG_PRESS_TICKS: long_ticks_q <= cfg_wdata_i[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  assign pressed = adc_sample_i < threshold_q;
  assign due     = deb_cnt_q == '0;
  assign limit   = HOLD_RELOAD - long_ticks_q;

  // Next state for one accepted request; ticks count down, polls step the machine.
  always_comb begin
    stage_d           = stage_q;
    deb_cnt_d         = deb_cnt_q;
    hold_cnt_d        = hold_cnt_q;
    evt_o.press_event = EVT_NONE;
    if (req_type_i == REQ_TICK) begin
      if (deb_cnt_q != '0) deb_cnt_d = deb_cnt_q - 1'b1;
      if (hold_cnt_q != '0) hold_cnt_d = hold_cnt_q - 1'b1;
    end else begin
      unique case (stage_q)
        ST_IDLE: begin
          if (due) begin
            deb_cnt_d = deb_ticks_q;
            if (pressed) stage_d = ST_CONFIRM;
          end
        end
        ST_CONFIRM: begin
          if (due) begin
            if (pressed) begin
              stage_d    = ST_HELD;
              hold_cnt_d = HOLD_RELOAD;
            end else begin
              stage_d = ST_IDLE;
            end
          end
        end
        ST_HELD: begin
          if (hold_cnt_q < limit) begin
            evt_o.press_event = EVT_LONG;
            stage_d           = ST_LONG;
          end else if (due) begin
            deb_cnt_d = deb_ticks_q;
            if (!pressed) stage_d = ST_RELEASE;
          end
        end
        ST_RELEASE: begin
          if (due && !pressed) begin
            stage_d           = ST_IDLE;
            evt_o.press_event = EVT_SHORT;
          end
        end
        ST_LONG: begin
          // The test here is on a held button, kept as the behavior defines it.
          if (due) begin
            deb_cnt_d = deb_ticks_q;
            if (pressed) stage_d = ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (due && !pressed) stage_d = ST_IDLE;
        end
        default: stage_d = ST_IDLE;
      endcase
    end
  end

  // State update on each request transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= ST_IDLE;
      deb_cnt_q  <= '0;
      hold_cnt_q <= '0;
    end else if (push_i) begin
      stage_q    <= stage_d;
      deb_cnt_q  <= deb_cnt_d;
      hold_cnt_q <= hold_cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bdsl_out_buf.sv =====
// Two-entry output buffer that keeps the request side moving while the event sink stalls.
`timescale 1ns / 1ps
`default_nettype none

module bdsl_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bdsl_pkg::evt_t evt_i,
  output logic               ready_o,
  bdsl_evt_if.source         evt_o
);
  import bdsl_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  evt_t out_q, out_d;
  evt_t skid_q, skid_d;
  logic pop;

  assign ready_o = !skid_valid_q;
  assign pop     = out_valid_q && evt_o.ready;

  // The output slot refills from the skid entry first, so order is kept.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push_i;
        skid_d       = evt_i;
      end else begin
        out_valid_d = push_i;
        out_d       = evt_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = evt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign evt_o.valid       = out_valid_q;
  assign evt_o.press_event = out_q.press_event;

endmodule

`default_nettype wire

// ===== hw/rtl/button_debounce_short_long_press_core.sv =====
// Top level of the push-button debounce and short/long press qualifier.
//
// Requests arrive on req_i: req_type 0 is a timer tick that counts the debounce
// and hold counters down toward zero, req_type 1 is a poll that carries a 10-bit
// button sample (pressed when below the threshold) and steps the qualifier.
// Every request transfer yields exactly one event on evt_o: 0 none, 1 short press
// released, 2 long press detected.
// The qualifier updates its state in the cycle of the transfer and writes the
// event into the output register, or into the skid entry while that register is full.
// One request is taken every cycle while the skid entry is empty.
// When the event sink stalls, a second event is held in a skid entry and
// req_i.ready drops only once both entries are full.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i while
// the block is idle; index 3 is ignored.
// Reset clears the stage and both counters, empties the output buffer and loads
// threshold 255, debounce period 5 and long press time 100.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_short_long_press_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bdsl_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [bdsl_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  bdsl_req_if.sink                               req_i,
  bdsl_evt_if.source                             evt_o
);
  import bdsl_pkg::*;

  logic buf_ready;
  logic push;
  evt_t evt;

  assign req_i.ready = buf_ready;
  assign push        = req_i.valid && buf_ready;

  // Qualifier state machine and counters.
  bdsl_qual u_qual (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push),
    .req_type_i   (req_i.req_type),
    .adc_sample_i (req_i.adc_sample),
    .evt_o        (evt)
  );

  // Event output register with skid entry.
  bdsl_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .evt_i   (evt),
    .ready_o (buf_ready),
    .evt_o   (evt_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the push-button short and long press qualifier.
`timescale 1ns / 1ps

module tb_top;
  import bdsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 100000;
  localparam int unsigned HOLD_OFF_CYCLES = 40;

  // Index 3 has no register behind it; writes there must be ignored.
  localparam logic [CfgIdxWidth-1:0] CFG_SPARE = 2'd3;

  // Qualifier stages as the block steps through them on polls.
  typedef enum logic [2:0] {
    ST_IDLE         = 3'd0,
    ST_CONFIRM      = 3'd1,
    ST_HELD         = 3'd2,
    ST_RELEASE      = 3'd3,
    ST_AFTER_LONG   = 3'd4,
    ST_WAIT_RELEASE = 3'd5
  } stage_e;

  // Tracks the qualifier state, predicts one press event per request transfer
  // and compares the events that come out against those predictions.
  class press_scoreboard;
    logic [SampleWidth-1:0] threshold;
    logic [CountWidth-1:0]  debounce_reload;
    logic [CountWidth-1:0]  long_ticks;
    stage_e                 stage;
    logic [CountWidth-1:0]  debounce_count;
    logic [CountWidth-1:0]  hold_count;
    logic [EventWidth-1:0]  expected_events[$];
    int unsigned            errors;

    function new();
      threshold       = PRESS_THRESHOLD_RST;
      debounce_reload = DEBOUNCE_TICKS_RST;
      long_ticks      = LONG_PRESS_TICKS_RST;
      stage           = ST_IDLE;
      debounce_count  = '0;
      hold_count      = '0;
      errors          = 0;
    endfunction

    function void write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        CFG_PRESS_THRESHOLD:  threshold       = data[SampleWidth-1:0];
        CFG_DEBOUNCE_TICKS:   debounce_reload = data[CountWidth-1:0];
        CFG_LONG_PRESS_TICKS: long_ticks      = data[CountWidth-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_events.size();
    endfunction

    // Steps the qualifier for one accepted request and queues its event.
    function void note_request(logic kind, logic [SampleWidth-1:0] sample);
      logic                  pressed;
      logic                  due;
      logic [CountWidth-1:0] long_limit;
      logic [EventWidth-1:0] ev;
      ev = EVT_NONE;
      if (kind == REQ_TICK) begin
        if (debounce_count != '0) debounce_count = debounce_count - 1'b1;
        if (hold_count != '0) hold_count = hold_count - 1'b1;
      end else begin
        pressed    = sample < threshold;
        due        = debounce_count == '0;
        long_limit = HOLD_RELOAD - long_ticks;
        case (stage)
          ST_IDLE: begin
            if (due) begin
              debounce_count = debounce_reload;
              if (pressed) stage = ST_CONFIRM;
            end
          end
          ST_CONFIRM: begin
            if (due) begin
              if (pressed) begin
                stage      = ST_HELD;
                hold_count = HOLD_RELOAD;
              end else begin
                stage = ST_IDLE;
              end
            end
          end
          ST_HELD: begin
            if (hold_count < long_limit) begin
              ev    = EVT_LONG;
              stage = ST_AFTER_LONG;
            end else if (due) begin
              debounce_count = debounce_reload;
              if (!pressed) stage = ST_RELEASE;
            end
          end
          ST_RELEASE: begin
            if (due && !pressed) begin
              stage = ST_IDLE;
              ev    = EVT_SHORT;
            end
          end
          // The re-check after a long press tests for a press, not a release.
          ST_AFTER_LONG: begin
            if (due) begin
              debounce_count = debounce_reload;
              if (pressed) stage = ST_WAIT_RELEASE;
            end
          end
          ST_WAIT_RELEASE: begin
            if (due && !pressed) stage = ST_IDLE;
          end
          default: stage = ST_IDLE;
        endcase
      end
      expected_events.push_back(ev);
    endfunction

    // Compares one event transfer with the oldest prediction.
    function void check_event(logic [EventWidth-1:0] ev);
      logic [EventWidth-1:0] want;
      if (expected_events.size() == 0) begin
        $display("%0t: press event %0d arrived with none expected", $time, ev);
        errors++;
      end else begin
        want = expected_events.pop_front();
        if (ev !== want) begin
          $display("%0t: press_event expected %0d, actual %0d", $time, want, ev);
          errors++;
        end
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_wdata_i;

  bdsl_req_if req_if ();
  bdsl_evt_if evt_if ();

  press_scoreboard sb = new();

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_off_req;
  bit          button_held;
  int unsigned cycles;

  button_debounce_short_long_press_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .evt_o      (evt_if)
  );

  always #6 clk_i = ~clk_i;

  // Run limit in case the block stops moving.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("button_debounce_short_long_press_core: mismatch");
      $finish;
    end
  end

  // Event sink: checks each transfer and stalls at random, with an occasional
  // long hold-off so that the output buffer fills and the input backs up.
  initial begin : event_sink
    int unsigned hold_left;
    logic        rdy;
    hold_left = 0;
    evt_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && evt_if.valid && evt_if.ready) sb.check_event(evt_if.press_event);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        rdy          = 1'b0;
      end else begin
        rdy = $urandom_range(0, 99) >= rcv_idle_pct;
      end
      evt_if.ready <= rdy;
    end
  end

  // Offers one request, with random idle cycles ahead of it.
  task automatic send_request(logic kind, logic [SampleWidth-1:0] sample);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.adc_sample <= sample;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(kind, sample);
  endtask

  // Stops offering and waits until every predicted event has been seen.
  task automatic drain_events();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  // A button reading on the pressed or released side of the threshold.
  function automatic logic [SampleWidth-1:0] button_sample(bit pressed);
    if (pressed && sb.threshold != '0) begin
      return SampleWidth'($urandom_range(0, sb.threshold - 1));
    end
    if (!pressed) return SampleWidth'($urandom_range(sb.threshold, 1023));
    return SampleWidth'($urandom_range(0, 1023));
  endfunction

  // Ticks and polls that follow a slowly changing button level, with bounce
  // and some fully random readings mixed in.
  task automatic random_requests(int unsigned n, int unsigned toggle_pct);
    int unsigned roll;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) hold_off_req = 1'b1;
      if ($urandom_range(0, 99) < toggle_pct) button_held = !button_held;
      roll = $urandom_range(0, 99);
      if (roll < 45) send_request(REQ_TICK, SampleWidth'($urandom_range(0, 1023)));
      else if (roll < 50) send_request(REQ_POLL, SampleWidth'($urandom_range(0, 1023)));
      else if (roll < 56) send_request(REQ_POLL, button_sample(!button_held));
      else send_request(REQ_POLL, button_sample(button_held));
    end
  endtask

  // Reprograms all registers while the block is idle, then runs a random burst.
  task automatic run_setting(logic [CfgDataWidth-1:0] thr, logic [CfgDataWidth-1:0] deb,
                             logic [CfgDataWidth-1:0] lng, int unsigned n,
                             int unsigned toggle_pct);
    drain_events();
    write_reg(CFG_PRESS_THRESHOLD, thr);
    write_reg(CFG_DEBOUNCE_TICKS, deb);
    write_reg(CFG_LONG_PRESS_TICKS, lng);
    write_reg(CFG_SPARE, CfgDataWidth'($urandom_range(0, 1023)));
    cfg_we_i <= 1'b0;
    random_requests(n, toggle_pct);
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_PRESS_THRESHOLD;
    cfg_wdata_i       <= '0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_TICK;
    req_if.adc_sample <= '0;
    hold_off_req = 1'b0;
    button_held  = 1'b0;
    cycles       = 0;
    snd_idle_pct = 15;
    rcv_idle_pct = 53;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed short press under the reset settings: ticks saturate at zero,
    // samples sit at both ends and right at the threshold.
    send_request(REQ_TICK, 10'd1023);
    send_request(REQ_POLL, 10'd1023);
    repeat (5) send_request(REQ_TICK, SampleWidth'($urandom_range(0, 1023)));
    send_request(REQ_POLL, 10'd0);
    send_request(REQ_POLL, 10'd254);
    repeat (5) send_request(REQ_TICK, SampleWidth'($urandom_range(0, 1023)));
    send_request(REQ_POLL, 10'd254);
    send_request(REQ_POLL, 10'd255);
    send_request(REQ_POLL, 10'd0);
    repeat (5) send_request(REQ_TICK, SampleWidth'($urandom_range(0, 1023)));
    send_request(REQ_POLL, 10'd1023);

    run_setting(10'd512, 10'd1, 10'd3, 260, 6);
    run_setting(10'd1023, 10'd2, 10'd0, 200, 6);

    snd_idle_pct = 53;
    rcv_idle_pct = 15;
    run_setting(10'd100, 10'd0, 10'd8, 240, 6);
    run_setting(10'd0, 10'd255, 10'd255, 60, 6);
    run_setting(10'd300, 10'd3, 10'd254, 180, 2);

    // Upper data bits must be dropped by the 8-bit registers.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_setting(10'd700, 10'h301, 10'h30c, 260, 5);
    run_setting(10'd255, 10'd5, 10'd100, 100, 3);

    drain_events();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("button_debounce_short_long_press_core: match");
    end else begin
      $display("button_debounce_short_long_press_core: mismatch");
    end
    $finish;
  end

endmodule
